/* src/erot_pkg.sv */
// Shared types, constants and sine table builder for the point rotation block.
`default_nettype none

package erot_pkg;

  localparam int COORD_W = 32;
  localparam int ANGLE_W = 12;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // pi and one in unsigned Q60
  localparam logic [63:0] PI_Q60  = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] ONE_Q60 = 64'd1 << 60;

  // Series terms taken for each table entry
  localparam int SERIES_TERMS = 30;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic signed [COORD_W-1:0] pivot_x;
    logic signed [COORD_W-1:0] pivot_y;
    logic signed [COORD_W-1:0] pivot_z;
    logic        [ANGLE_W-1:0] angle_about_x;
    logic        [ANGLE_W-1:0] angle_about_y;
    logic        [ANGLE_W-1:0] angle_about_z;
  } point_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] rotated_x;
    logic signed [COORD_W-1:0] rotated_y;
    logic signed [COORD_W-1:0] rotated_z;
    logic                      clipped;
  } result_word_t;

  // Bits [123:60] of the full unsigned product
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Unsigned quotient by restoring long division, for table building only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Angle step count as radians in Q60, rounded down
  function automatic logic [63:0] radians_q60(input int unsigned angle_bits,
                                              input logic [63:0] t);
    int unsigned sh;
    logic [63:0] mask;
    sh   = angle_bits - 1;
    mask = (64'd1 << sh) - 64'd1;
    return t * (PI_Q60 >> sh) + ((t * (PI_Q60 & mask)) >> sh);
  endfunction

  // Taylor series in Q60: sine for the odd series, cosine otherwise
  function automatic logic [63:0] series_q60(input logic [63:0] x, input logic odd_series);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] n;
    x2   = mul_q60(x, x);
    term = odd_series ? x : ONE_Q60;
    sum  = term;
    n    = odd_series ? 64'd1 : 64'd0;
    for (int k = 1; k < SERIES_TERMS; k++) begin
      if (term != 64'd0) begin
        term = udiv64(mul_q60(term, x2), (n + 64'd1) * (n + 64'd2));
        n    = n + 64'd2;
        if (k[0]) sum = sum - term;
        else      sum = sum + term;
      end
    end
    return sum;
  endfunction

  // Magnitude over the first quadrant, Q60
  function automatic logic [63:0] quarter_q60(input int unsigned angle_bits,
                                              input logic [63:0] t);
    logic [63:0] n4;
    n4 = 64'd1 << (angle_bits - 2);
    if (t <= (n4 >> 1)) return series_q60(radians_q60(angle_bits, t), 1'b1);
    return series_q60(radians_q60(angle_bits, n4 - t), 1'b0);
  endfunction

  // Rounded sine of a binary angle, scaled by 2^frac_bits
  function automatic logic signed [63:0] sine_value(input int unsigned angle_bits,
                                                    input int unsigned frac_bits,
                                                    input logic [63:0] a);
    logic [63:0] n4;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] m;
    logic signed [63:0] v;
    n4 = 64'd1 << (angle_bits - 2);
    q  = (a >> (angle_bits - 2)) & 64'd3;
    r  = a & (n4 - 64'd1);
    m  = q[0] ? quarter_q60(angle_bits, n4 - r) : quarter_q60(angle_bits, r);
    v  = $signed((m + (64'd1 << (59 - frac_bits))) >> (60 - frac_bits));
    return (q >= 64'd2) ? -v : v;
  endfunction

endpackage

`default_nettype wire

/* src/euler_rotate_point_about_origin.sv */
// Point rotation about a pivot by three binary angles, X then Y then Z, fully pipelined.
//
// Input channel point_valid / point_ready / point carries one word per point: the point,
// the pivot and three angles. Output channel result_valid / result_ready / result carries
// the rotated point and a clipped flag, set when any coordinate saturated at any step.
//
// The pipeline has 13 register stages: one for the sine/cosine ROM reads, then four per
// axis (pivot difference, multiply, sum and shift, pivot add and saturate). One word
// is taken and one result given every cycle while the receiver takes results; the figure
// is set by the ROM read port pair per axis and the multiplier bank of each axis stage,
// each used once per word.
//
// Every stage carries a valid bit and advances when its successor is empty or moving,
// so bubbles close up and words keep entering while a result waits to be taken.
// When the receiver stalls, words pile up behind the output register and point_ready
// falls only once every stage is full. Reset (rst, synchronous) clears the valid bits
// and so drops any words in flight; the sine tables are constant and need no clearing.
`default_nettype none

module euler_rotate_point_about_origin #(
  parameter int ANGLE_BITS     = 12,
  parameter int SINE_FRAC_BITS = 14
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   point_valid,
  output logic                   point_ready,
  input  erot_pkg::point_word_t  point,
  output logic                   result_valid,
  input  logic                   result_ready,
  output erot_pkg::result_word_t result
);

  import erot_pkg::*;

  localparam int TRIG_W  = SINE_FRAC_BITS + 2;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = DIFF_W + TRIG_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int SHIFT_W = SUM_W - SINE_FRAC_BITS;
  localparam int ACC_W   = SHIFT_W + 1;
  localparam int DEPTH   = 2 ** ANGLE_BITS;
  localparam int NROT    = 3;
  localparam int SPR     = 4;
  localparam int NST     = 1 + NROT * SPR;
  localparam logic [ANGLE_BITS-1:0] QTR = ANGLE_BITS'(2 ** (ANGLE_BITS - 2));

  typedef struct packed {
    logic [NROT-1:0][COORD_W-1:0] pt;
    logic [NROT-1:0][COORD_W-1:0] pv;
    logic [NROT-1:0][TRIG_W-1:0]  sn;
    logic [NROT-1:0][TRIG_W-1:0]  cs;
    logic                         flag;
  } carry_t;

  logic [NST-1:0] vld;
  logic [NST-1:0] en;
  carry_t         ctx [NST];

  // Handshake: a stage loads when it is empty or its contents move on
  assign en[NST-1] = !vld[NST-1] || result_ready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  assign point_ready = en[0] && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= point_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Sine tables, one copy per axis so each is read at two addresses
  logic signed [TRIG_W-1:0] sine_tab [NROT][DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_tab
    localparam logic signed [TRIG_W-1:0] ENTRY =
      TRIG_W'(sine_value(ANGLE_BITS, SINE_FRAC_BITS, 64'(g)));
    for (genvar ax = 0; ax < NROT; ax++) begin : g_axis
      assign sine_tab[ax][g] = ENTRY;
    end
  end

  logic [ANGLE_BITS-1:0] sin_addr [NROT];
  logic [ANGLE_BITS-1:0] cos_addr [NROT];

  // Drop angle bits above a full turn
  assign sin_addr[0] = ANGLE_BITS'(point.angle_about_x);
  assign sin_addr[1] = ANGLE_BITS'(point.angle_about_y);
  assign sin_addr[2] = ANGLE_BITS'(point.angle_about_z);

  for (genvar ax = 0; ax < NROT; ax++) begin : g_cos
    assign cos_addr[ax] = sin_addr[ax] + QTR;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int ax = 0; ax < NROT; ax++) begin
        ctx[0].sn[ax] <= sine_tab[ax][sin_addr[ax]];
        ctx[0].cs[ax] <= sine_tab[ax][cos_addr[ax]];
      end
      ctx[0].pt   <= {point.point_z, point.point_y, point.point_x};
      ctx[0].pv   <= {point.pivot_z, point.pivot_y, point.pivot_x};
      ctx[0].flag <= 1'b0;
    end
  end

  // One rotation per axis: X turns (y,z), Y turns (z,x), Z turns (x,y)
  for (genvar r = 0; r < NROT; r++) begin : g_rot
    localparam int U  = (r + 1) % NROT;
    localparam int V  = (r + 2) % NROT;
    localparam int KD = 1 + SPR * r;
    localparam int KM = KD + 1;
    localparam int KS = KD + 2;
    localparam int KP = KD + 3;

    logic signed [DIFF_W-1:0]  du;
    logic signed [DIFF_W-1:0]  dv;
    logic signed [PROD_W-1:0]  p_uc;
    logic signed [PROD_W-1:0]  p_vs;
    logic signed [PROD_W-1:0]  p_us;
    logic signed [PROD_W-1:0]  p_vc;
    logic signed [SUM_W-1:0]   sum_u;
    logic signed [SUM_W-1:0]   sum_v;
    logic signed [SHIFT_W-1:0] su;
    logic signed [SHIFT_W-1:0] sv;
    logic signed [ACC_W-1:0]   au;
    logic signed [ACC_W-1:0]   av;
    logic                      hi_u;
    logic                      lo_u;
    logic                      hi_v;
    logic                      lo_v;
    carry_t                    ctx_next;

    always_comb begin
      sum_u = SUM_W'(p_uc) - SUM_W'(p_vs);
      sum_v = SUM_W'(p_us) + SUM_W'(p_vc);
      au    = ACC_W'(su) + ACC_W'($signed(ctx[KP-1].pv[U]));
      av    = ACC_W'(sv) + ACC_W'($signed(ctx[KP-1].pv[V]));
      hi_u  = au > ACC_W'(COORD_MAX);
      lo_u  = au < ACC_W'(COORD_MIN);
      hi_v  = av > ACC_W'(COORD_MAX);
      lo_v  = av < ACC_W'(COORD_MIN);
      ctx_next       = ctx[KP-1];
      ctx_next.pt[U] = hi_u ? COORD_MAX : (lo_u ? COORD_MIN : au[COORD_W-1:0]);
      ctx_next.pt[V] = hi_v ? COORD_MAX : (lo_v ? COORD_MIN : av[COORD_W-1:0]);
      ctx_next.flag  = ctx[KP-1].flag | hi_u | lo_u | hi_v | lo_v;
    end

    always_ff @(posedge clk) begin
      if (en[KD]) begin
        ctx[KD] <= ctx[KD-1];
        du <= DIFF_W'($signed(ctx[KD-1].pt[U])) - DIFF_W'($signed(ctx[KD-1].pv[U]));
        dv <= DIFF_W'($signed(ctx[KD-1].pt[V])) - DIFF_W'($signed(ctx[KD-1].pv[V]));
      end
      if (en[KM]) begin
        ctx[KM] <= ctx[KM-1];
        p_uc <= du * $signed(ctx[KM-1].cs[r]);
        p_vs <= dv * $signed(ctx[KM-1].sn[r]);
        p_us <= du * $signed(ctx[KM-1].sn[r]);
        p_vc <= dv * $signed(ctx[KM-1].cs[r]);
      end
      if (en[KS]) begin
        ctx[KS] <= ctx[KS-1];
        // Arithmetic shift rounds toward minus infinity
        su <= SHIFT_W'(sum_u >>> SINE_FRAC_BITS);
        sv <= SHIFT_W'(sum_v >>> SINE_FRAC_BITS);
      end
      if (en[KP]) begin
        ctx[KP] <= ctx_next;
      end
    end
  end

  assign result_valid     = vld[NST-1];
  assign result.rotated_x = $signed(ctx[NST-1].pt[0]);
  assign result.rotated_y = $signed(ctx[NST-1].pt[1]);
  assign result.rotated_z = $signed(ctx[NST-1].pt[2]);
  assign result.clipped   = ctx[NST-1].flag;

  // An empty output stage lets every stage load
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !vld[NST-1] |-> point_ready)
    else $error("input stalled while the output stage is empty");

  // Words in flight change only by what enters and leaves
  a_word_count: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |->
      ($countones(vld) + $past(result_valid && result_ready) ==
       $past($countones(vld)) + $past(point_valid && point_ready)))
    else $error("word lost or repeated in the pipeline");

  // A blocked first stage holds its word
  a_first_stage_hold: assert property (@(posedge clk) disable iff (rst)
    vld[0] && !en[1] |=> vld[0] && $stable(ctx[0]))
    else $error("first stage changed while blocked");

endmodule

`default_nettype wire
